// File: hdl/acm_pkg.sv
// shared types, constants and helper functions of the crosspoint mixer
package acm_pkg;

    // channel and sample geometry
    localparam int CHANNELS    = 16;
    localparam int CH_BITS     = 4;
    localparam int CNT_BITS    = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int ACC_BITS    = SAMPLE_BITS + 4;

    // configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_COUNT  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_COUNT = 4'd1;
    localparam logic [CNT_BITS-1:0]     COUNT_RESET      = 5'd2;

    // request op codes
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_IN_MUTE  = 2'd1;
    localparam logic [1:0] OP_OUT_MUTE = 2'd2;
    localparam logic [1:0] OP_XPOINT   = 2'd3;

    // command queue geometry
    localparam int QDEPTH    = 4;
    localparam int QIDX_BITS = 2;
    localparam int QCNT_BITS = 3;

    // classified request as held in the command queue
    typedef struct packed {
        logic [1:0]                    kind;
        logic [CH_BITS-1:0]            in_ch;
        logic [CH_BITS-1:0]            out_ch;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          flag;
        logic                          frame_end;
        logic                          in_active;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic                 empty;
        logic                 full;
        logic [QCNT_BITS-1:0] level;
    } q_stat_t;

    // a count of zero acts as one, above the channel total as the total
    function automatic logic [CNT_BITS-1:0] active_count(input logic [CNT_BITS-1:0] count);
        logic [CNT_BITS-1:0] res;
        if (count == '0)
            res = CNT_BITS'(1);
        else if (count > CNT_BITS'(CHANNELS))
            res = CNT_BITS'(CHANNELS);
        else
            res = count;
        return res;
    endfunction

endpackage

// File: hdl/acm_front.sv
// front end: accepts requests and classifies them into queue commands
module acm_front
    import acm_pkg::*;
(
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [CH_BITS-1:0]            in_channel,
    input  logic [CH_BITS-1:0]            out_channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          flag_value,
    input  logic                          frame_end,
    input  logic [CNT_BITS-1:0]           in_active,
    input  q_stat_t                       q_stat,
    output logic                          push,
    output cmd_t                          cmd
);

    // accept whenever the queue has room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify the request
    always_comb
    begin
        cmd.kind      = op;
        cmd.in_ch     = in_channel;
        cmd.out_ch    = out_channel;
        cmd.sample    = sample_in;
        cmd.flag      = flag_value;
        // frame end only counts on a sample
        cmd.frame_end = (op == OP_SAMPLE) && frame_end;
        // inputs at or above the active count are not mixed
        cmd.in_active = {1'b0, in_channel} < in_active;
    end

endmodule

// File: hdl/acm_queue.sv
// short command queue between front end and mixing engine
module acm_queue
    import acm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    wr_cmd,
    input  logic    pop,
    output cmd_t    rd_cmd,
    output q_stat_t q_stat
);

    cmd_t                 mem_reg [QDEPTH];
    logic [QIDX_BITS-1:0] wr_ptr_reg;
    logic [QIDX_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] level_reg;

    // status and head of queue
    assign q_stat.level = level_reg;
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.full  = (level_reg == QCNT_BITS'(QDEPTH));
    assign rd_cmd       = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QIDX_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QIDX_BITS'(1);
            if (push && !pop)
                level_reg <= level_reg + QCNT_BITS'(1);
            else if (pop && !push)
                level_reg <= level_reg - QCNT_BITS'(1);
        end
    end

endmodule

// File: hdl/acm_back.sv
// mixing engine: routing state, accumulators and frame emission
module acm_back
    import acm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  q_stat_t                       q_stat,
    input  cmd_t                          cmd,
    output logic                          pop,
    input  logic [CNT_BITS-1:0]           out_active,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [CH_BITS-1:0]            out_index,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic [CH_BITS-1:0]            cnt_reg;
    logic signed [ACC_BITS-1:0]    acc_reg [CHANNELS];
    logic [CHANNELS-1:0]           xpt_reg [CHANNELS];
    logic [CHANNELS-1:0]           in_mute_reg;
    logic [CHANNELS-1:0]           out_mute_reg;
    logic                          out_valid_reg;
    logic [CH_BITS-1:0]            out_index_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          last_reg;

    logic                          take;
    logic [CHANNELS-1:0]           row;
    logic signed [ACC_BITS-1:0]    sat_sum [CHANNELS];
    logic                          emit_step;
    logic                          emit_last;
    logic signed [ACC_BITS-1:0]    acc_sel;
    logic signed [SAMPLE_BITS-1:0] emit_val;

    // dispatch one command when not emitting
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign row       = xpt_reg[cmd.in_ch];
    assign take      = pop && (cmd.kind == OP_SAMPLE) && cmd.in_active
                       && !in_mute_reg[cmd.in_ch];
    assign emit_step = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_last = ({1'b0, cnt_reg} + CNT_BITS'(1)) == out_active;

    // saturating add in every output lane
    always_comb
    begin
        logic signed [ACC_BITS:0] sum;
        for (int o = 0; o < CHANNELS; o++)
        begin
            sum = {acc_reg[o][ACC_BITS-1], acc_reg[o]}
                  + (ACC_BITS+1)'(cmd.sample);
            if (sum[ACC_BITS] != sum[ACC_BITS-1])
                sat_sum[o] = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                           : {1'b0, {(ACC_BITS-1){1'b1}}};
            else
                sat_sum[o] = sum[ACC_BITS-1:0];
        end
    end

    // result value: narrow with saturation, zero when muted
    always_comb
    begin
        acc_sel = acc_reg[cnt_reg];
        if (acc_sel[ACC_BITS-1:SAMPLE_BITS-1] != '0 &&
            acc_sel[ACC_BITS-1:SAMPLE_BITS-1] != '1)
            emit_val = acc_sel[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            emit_val = acc_sel[SAMPLE_BITS-1:0];
        if (out_mute_reg[cnt_reg])
            emit_val = '0;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && cmd.frame_end)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_step && emit_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer and frame counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cnt_reg <= '0;
            else if (emit_step)
                cnt_reg <= cnt_reg + CH_BITS'(1);
        end
    end

    // routing matrix and mutes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                xpt_reg[i] <= CHANNELS'(1) << i;
            in_mute_reg  <= '0;
            out_mute_reg <= '0;
        end
        else if (pop)
        begin
            unique case (cmd.kind)
                OP_IN_MUTE:  in_mute_reg[cmd.in_ch]       <= cmd.flag;
                OP_OUT_MUTE: out_mute_reg[cmd.out_ch]     <= cmd.flag;
                OP_XPOINT:   xpt_reg[cmd.in_ch][cmd.out_ch] <= cmd.flag;
                default:     ;
            endcase
        end
    end

    // accumulators: mix on samples, clear after the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < CHANNELS; o++)
                acc_reg[o] <= '0;
        end
        else if (take)
        begin
            for (int o = 0; o < CHANNELS; o++)
                if (row[o])
                    acc_reg[o] <= sat_sum[o];
        end
        else if (emit_step && emit_last)
        begin
            for (int o = 0; o < CHANNELS; o++)
                acc_reg[o] <= '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            out_index_reg  <= cnt_reg;
            sample_out_reg <= emit_val;
            last_reg       <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign sample_out = sample_out_reg;
    assign last       = last_reg;

endmodule

// File: hdl/audio_crosspoint_matrix_mixer.sv
// top level of the audio crosspoint matrix mixer
// Requests (samples, mute and crosspoint settings) are taken one per clock while the
// four-entry command queue has room, and the mixing engine retires one per clock
// while not emitting a frame; all sixteen output lanes add a sample in parallel.
// A sample carrying frame_end makes the engine emit output_count results, one per
// clock through its output register unless the output side stalls, and it takes
// no further command until the last has been loaded; meanwhile the queue keeps
// accepting up to four requests. Mutes and routing are kept across count register
// writes.
module audio_crosspoint_matrix_mixer
    import acm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [CH_BITS-1:0]            in_channel,
    input  logic [CH_BITS-1:0]            out_channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          flag_value,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [CH_BITS-1:0]            out_index,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          last
);

    logic [CNT_BITS-1:0] input_count_reg;
    logic [CNT_BITS-1:0] output_count_reg;
    logic [CNT_BITS-1:0] in_active;
    logic [CNT_BITS-1:0] out_active;
    q_stat_t             q_stat;
    cmd_t                wr_cmd;
    cmd_t                rd_cmd;
    logic                push;
    logic                pop;

    // count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= COUNT_RESET;
            output_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_INPUT_COUNT)
                input_count_reg <= cfg_data;
            else if (cfg_index == REG_OUTPUT_COUNT)
                output_count_reg <= cfg_data;
        end
    end

    assign in_active  = active_count(input_count_reg);
    assign out_active = active_count(output_count_reg);

    // front end
    acm_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .in_channel  (in_channel),
        .out_channel (out_channel),
        .sample_in   (sample_in),
        .flag_value  (flag_value),
        .frame_end   (frame_end),
        .in_active   (in_active),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (wr_cmd)
    );

    // command queue
    acm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .q_stat (q_stat)
    );

    // mixing engine
    acm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .cmd        (rd_cmd),
        .pop        (pop),
        .out_active (out_active),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .sample_out (sample_out),
        .last       (last)
    );

`ifndef SYNTHESIS
    // the final result of a frame belongs to the last active output
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ({1'b0, out_index} + CNT_BITS'(1)) == out_active)
        else $error("last result on wrong output index");

    // the queue never overfills
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QCNT_BITS'(QDEPTH))
        else $error("command queue overfilled");

    // the engine only takes commands that are there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command taken from empty queue");

    // a request accepted into a full queue would be lost
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_stat.full) |-> 1'b0)
        else $error("request pushed into full queue");
`endif

endmodule

// File: tb/acm_checker.sv
// request and result monitor with a bit-accurate mixer predictor and result scoreboard
`timescale 1ns / 1ps

module acm_checker
    import acm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [CH_BITS-1:0]            in_channel,
    input  logic [CH_BITS-1:0]            out_channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          flag_value,
    input  logic                          frame_end,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [CH_BITS-1:0]            out_index,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          last,
    output int                            results_due,
    output int                            errors
);

    // one mixed output sample as it should leave the block
    typedef struct {
        logic [CH_BITS-1:0]            index;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
    } mix_out_t;

    localparam longint ACC_TOP    = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_BITS - 1));
    localparam longint SMP_TOP    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_BOTTOM = -(longint'(1) <<< (SAMPLE_BITS - 1));

    // shadow copy of the mixer state
    logic signed [ACC_BITS-1:0] bus_sum [CHANNELS];
    logic [CHANNELS-1:0]        route [CHANNELS];
    logic [CHANNELS-1:0]        in_muted;
    logic [CHANNELS-1:0]        out_muted;
    logic [CNT_BITS-1:0]        in_count;
    logic [CNT_BITS-1:0]        out_count;

    mix_out_t frame_q [$];
    mix_out_t due;
    int       err_total;

    // zero counts as one channel, anything above the total as the total
    function automatic int lanes(input logic [CNT_BITS-1:0] count);
        if (count == '0)
            return 1;
        if (count > CHANNELS)
            return CHANNELS;
        return int'(count);
    endfunction

    // apply one request to the shadow state, queueing a frame on frame end
    task automatic mix_request(
        input logic [1:0]                    r_op,
        input logic [CH_BITS-1:0]            ich,
        input logic [CH_BITS-1:0]            och,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic                          flg,
        input logic                          fend
    );
        longint   sum;
        mix_out_t res;
        int       n;
        case (r_op)
            OP_IN_MUTE:  in_muted[ich] = flg;
            OP_OUT_MUTE: out_muted[och] = flg;
            OP_XPOINT:   route[ich][och] = flg;
            default:
            begin
                // add into every routed bus, saturating at the accumulator range
                if (ich < lanes(in_count) && !in_muted[ich])
                begin
                    for (int o = 0; o < CHANNELS; o++)
                    begin
                        if (route[ich][o])
                        begin
                            sum = longint'(bus_sum[o]) + longint'(smp);
                            if (sum > ACC_TOP)
                                sum = ACC_TOP;
                            if (sum < ACC_BOTTOM)
                                sum = ACC_BOTTOM;
                            bus_sum[o] = ACC_BITS'(sum);
                        end
                    end
                end
                // emit the frame and clear all buses
                if (fend)
                begin
                    n = lanes(out_count);
                    for (int o = 0; o < n; o++)
                    begin
                        sum = longint'(bus_sum[o]);
                        if (sum > SMP_TOP)
                            sum = SMP_TOP;
                        if (sum < SMP_BOTTOM)
                            sum = SMP_BOTTOM;
                        if (out_muted[o])
                            sum = 0;
                        res.index = CH_BITS'(o);
                        res.value = SAMPLE_BITS'(sum);
                        res.last  = (o == n - 1);
                        frame_q = {frame_q, res};
                    end
                    for (int o = 0; o < CHANNELS; o++)
                        bus_sum[o] = '0;
                end
            end
        endcase
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                bus_sum[i]  = '0;
                route[i]    = '0;
                route[i][i] = 1'b1;
            end
            in_muted  = '0;
            out_muted = '0;
            in_count  = COUNT_RESET;
            out_count = COUNT_RESET;
            frame_q.delete();
            err_total = 0;
            results_due <= 0;
            errors      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_INPUT_COUNT)
                    in_count = cfg_data;
                else if (cfg_index == REG_OUTPUT_COUNT)
                    out_count = cfg_data;
            end
            if (in_valid && !in_stall)
                mix_request(op, in_channel, out_channel, sample_in, flag_value, frame_end);
            if (out_valid && !out_stall)
            begin
                if (frame_q.size() == 0)
                begin
                    $error("out_index: expected no result, actual %0d", out_index);
                    err_total++;
                end
                else
                begin
                    due = frame_q.pop_front();
                    if (out_index !== due.index)
                    begin
                        $error("out_index: expected %0d, actual %0d", due.index, out_index);
                        err_total++;
                    end
                    if (sample_out !== due.value)
                    begin
                        $error("sample_out: expected %0d, actual %0d", due.value, sample_out);
                        err_total++;
                    end
                    if (last !== due.last)
                    begin
                        $error("last: expected %0b, actual %0b", due.last, last);
                        err_total++;
                    end
                end
            end
            results_due <= frame_q.size();
            errors      <= err_total;
        end
    end

endmodule

// File: tb/tb.sv
// stimulus, clock, reset and verdict for the crosspoint mixer testbench
`timescale 1ns / 1ps

module tb
    import acm_pkg::*;
();

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;
    localparam logic [CFG_IDX_BITS-1:0]       REG_UNUSED = 4'd9;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [1:0]                    op = OP_SAMPLE;
    logic [CH_BITS-1:0]            in_channel = '0;
    logic [CH_BITS-1:0]            out_channel = '0;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          flag_value = 1'b0;
    logic                          frame_end = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [CH_BITS-1:0]            out_index;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last;

    int results_due;
    int errors;
    int quiet_cycles = 0;
    int items_sent = 0;
    int in_lanes = 2;
    int out_lanes = 2;
    bit calm = 1'b0;

    audio_crosspoint_matrix_mixer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .in_channel  (in_channel),
        .out_channel (out_channel),
        .sample_in   (sample_in),
        .flag_value  (flag_value),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_index   (out_index),
        .sample_out  (sample_out),
        .last        (last)
    );

    acm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .in_channel  (in_channel),
        .out_channel (out_channel),
        .sample_in   (sample_in),
        .flag_value  (flag_value),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_index   (out_index),
        .sample_out  (sample_out),
        .last        (last),
        .results_due (results_due),
        .errors      (errors)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 26);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL audio_crosspoint_matrix_mixer");
            $finish;
        end
    end

    // present one request, with random idle cycles ahead of it
    task automatic send_req(
        input logic [1:0]                    r_op,
        input logic [CH_BITS-1:0]            ich,
        input logic [CH_BITS-1:0]            och,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic                          flg,
        input logic                          fend
    );
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= r_op;
        in_channel  <= ich;
        out_channel <= och;
        sample_in   <= smp;
        flag_value  <= flg;
        frame_end   <= fend;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // single register write, then the enable is taken low again before returning
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_counts(input logic [CNT_BITS-1:0] n_in, input logic [CNT_BITS-1:0] n_out);
        write_reg(REG_INPUT_COUNT, n_in);
        write_reg(REG_OUTPUT_COUNT, n_out);
        in_lanes  = (n_in == 0) ? 1 : (n_in > CHANNELS) ? CHANNELS : int'(n_in);
        out_lanes = (n_out == 0) ? 1 : (n_out > CHANNELS) ? CHANNELS : int'(n_out);
    endtask

    // drain all results, then give requests with no result time to retire
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // drive one bus past the accumulator range, then pull it back
    task automatic saturate_burst();
        logic [CH_BITS-1:0] ich;
        logic [CH_BITS-1:0] och;
        bit                 up;
        ich = CH_BITS'($urandom_range(in_lanes - 1));
        och = CH_BITS'($urandom_range(out_lanes - 1));
        up  = 1'($urandom_range(1));
        send_req(OP_IN_MUTE, ich, och, '0, 1'b0, 1'b0);
        send_req(OP_OUT_MUTE, ich, och, '0, 1'b0, 1'b0);
        send_req(OP_XPOINT, ich, och, '0, 1'b1, 1'b0);
        repeat (17) send_req(OP_SAMPLE, ich, och, up ? SMP_MAX : SMP_MIN, 1'b0, 1'b0);
        for (int i = 0; i < 16; i++)
            send_req(OP_SAMPLE, ich, och, up ? SMP_MIN : SMP_MAX, 1'b0, i == 15);
    endtask

    // mostly whole frames with random content, some settings, some noise
    task automatic random_traffic(input int quota);
        int start;
        int pick;
        int n;
        logic [1:0] set_op;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_req(OP_SAMPLE,
                             ($urandom_range(9) < 8) ? CH_BITS'($urandom_range(in_lanes - 1))
                                                     : CH_BITS'($urandom),
                             CH_BITS'($urandom), pick_sample(), 1'($urandom), i == n - 1);
            end
            else if (pick < 80)
            begin
                set_op = 2'($urandom_range(1, 3));
                send_req(set_op, CH_BITS'($urandom), CH_BITS'($urandom), pick_sample(),
                         (set_op == OP_XPOINT) ? 1'($urandom) : ($urandom_range(3) == 0),
                         1'($urandom));
            end
            else if (pick < 83)
            begin
                saturate_burst();
            end
            else
            begin
                send_req(2'($urandom), CH_BITS'($urandom), CH_BITS'($urandom),
                         SAMPLE_BITS'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset counts: extremes on both active inputs through the identity matrix
        send_req(OP_SAMPLE, 4'd0, 4'd15, SMP_MAX, 1'b1, 1'b0);
        send_req(OP_SAMPLE, 4'd1, 4'd0, SMP_MIN, 1'b0, 1'b1);
        // inactive input is dropped but its frame end still acts
        send_req(OP_SAMPLE, 4'd15, 4'd0, 24'sd123, 1'b0, 1'b1);
        // muted input
        send_req(OP_IN_MUTE, 4'd0, 4'd0, '0, 1'b1, 1'b0);
        send_req(OP_SAMPLE, 4'd0, 4'd0, 24'sd500, 1'b0, 1'b0);
        send_req(OP_SAMPLE, 4'd1, 4'd0, 24'sd7, 1'b0, 1'b1);
        send_req(OP_IN_MUTE, 4'd0, 4'd0, '0, 1'b0, 1'b0);
        // muted output gives zero
        send_req(OP_OUT_MUTE, 4'd0, 4'd1, '0, 1'b1, 1'b0);
        send_req(OP_SAMPLE, 4'd1, 4'd1, 24'sd9, 1'b0, 1'b1);
        send_req(OP_OUT_MUTE, 4'd0, 4'd1, '0, 1'b0, 1'b0);
        // two inputs on one bus saturate at the sample range
        send_req(OP_XPOINT, 4'd1, 4'd0, '0, 1'b1, 1'b0);
        send_req(OP_SAMPLE, 4'd0, 4'd0, SMP_MAX, 1'b0, 1'b0);
        send_req(OP_SAMPLE, 4'd1, 4'd0, SMP_MAX, 1'b0, 1'b1);
        send_req(OP_SAMPLE, 4'd0, 4'd0, SMP_MIN, 1'b0, 1'b0);
        send_req(OP_SAMPLE, 4'd1, 4'd0, SMP_MIN, 1'b0, 1'b1);
        // frame end on a setting request is ignored
        send_req(OP_XPOINT, 4'd1, 4'd0, '0, 1'b0, 1'b1);
        send_req(OP_SAMPLE, 4'd1, 4'd0, -24'sd5, 1'b0, 1'b1);
        // identity crosspoint switched off and back on
        send_req(OP_XPOINT, 4'd0, 4'd0, '0, 1'b0, 1'b0);
        send_req(OP_SAMPLE, 4'd0, 4'd0, SMP_MIN, 1'b0, 1'b1);
        send_req(OP_XPOINT, 4'd0, 4'd0, '0, 1'b1, 1'b0);
        // settings on inactive channels still take effect
        send_req(OP_XPOINT, 4'd15, 4'd15, '0, 1'b1, 1'b0);
        send_req(OP_OUT_MUTE, 4'd15, 4'd15, '0, 1'b1, 1'b0);
        send_req(OP_SAMPLE, 4'd0, 4'd0, 24'sd1, 1'b0, 1'b1);
        quiesce();

        // full width with no idling at all
        calm = 1'b1;
        set_counts(5'd16, 5'd16);
        saturate_burst();
        random_traffic(30);
        quiesce();
        calm = 1'b0;

        // single channel, plus a write to an index outside the register list
        set_counts(5'd1, 5'd1);
        write_reg(REG_UNUSED, 5'd7);
        random_traffic(25);
        quiesce();

        // zero and oversize counts
        set_counts(5'd0, 5'd0);
        random_traffic(20);
        quiesce();
        set_counts(5'd31, 5'd17);
        random_traffic(20);
        quiesce();

        set_counts(5'd5, 5'd3);
        random_traffic(30);
        quiesce();

        repeat (2)
        begin
            set_counts(CNT_BITS'($urandom), CNT_BITS'($urandom));
            random_traffic(25);
            quiesce();
        end

        if (errors == 0)
            $display("PASS audio_crosspoint_matrix_mixer");
        else
            $display("FAIL audio_crosspoint_matrix_mixer");
        $finish;
    end

endmodule
